### rtl/core/cdt_pkg.sv
// Shared constants for the CDT base Gaussian sampler: widths, row count
// and the threshold table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdt_pkg;

  localparam int LIMB_W   = 24;
  localparam int VALUE_W  = 3 * LIMB_W;
  localparam int ROWS     = 18;
  localparam int COUNT_W  = $clog2(ROWS + 1);
  localparam int SAMPLE_W = 6;
  localparam int SQUARE_W = 9;

  // Decreasing thresholds, each written as {high, mid, low} limbs.
  localparam logic [VALUE_W-1:0] CDT_THRESHOLD [ROWS] = '{
    {24'd10745844, 24'd3068844,  24'd3741698},
    {24'd5559083,  24'd1580863,  24'd8248194},
    {24'd2260429,  24'd13669192, 24'd2736639},
    {24'd708981,   24'd4421575,  24'd10046180},
    {24'd169348,   24'd7122675,  24'd4136815},
    {24'd30538,    24'd13063405, 24'd7650655},
    {24'd4132,     24'd14505003, 24'd7826148},
    {24'd417,      24'd16768101, 24'd11363290},
    {24'd31,       24'd8444042,  24'd8086568},
    {24'd1,        24'd12844466, 24'd265321},
    {24'd0,        24'd1232676,  24'd13644283},
    {24'd0,        24'd38047,    24'd9111839},
    {24'd0,        24'd870,      24'd6138264},
    {24'd0,        24'd14,       24'd12545723},
    {24'd0,        24'd0,        24'd3104126},
    {24'd0,        24'd0,        24'd28824},
    {24'd0,        24'd0,        24'd198},
    {24'd0,        24'd0,        24'd1}
  };

endpackage

`default_nettype wire

### rtl/core/cdt_if.sv
// Valid/ready channel interfaces for the sampler's random input and its
// sample output. Depends on cdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cdt_in_if;
  logic                        valid;
  logic                        ready;
  logic [cdt_pkg::LIMB_W-1:0]  low_limb;
  logic [cdt_pkg::LIMB_W-1:0]  mid_limb;
  logic [cdt_pkg::LIMB_W-1:0]  high_limb;
  logic                        sign_bit;

  modport source (output valid, low_limb, mid_limb, high_limb, sign_bit, input ready);
  modport sink   (input valid, low_limb, mid_limb, high_limb, sign_bit, output ready);
endinterface

interface cdt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cdt_pkg::SAMPLE_W-1:0] bimodal_sample;
  logic [cdt_pkg::SQUARE_W-1:0]        count_squared;

  modport source (output valid, bimodal_sample, count_squared, input ready);
  modport sink   (input valid, bimodal_sample, count_squared, output ready);
endinterface

`default_nettype wire

### rtl/core/cdt_base_gaussian_sampler_unit.sv
// CDT base Gaussian sampler, four-stage pipeline.
// Depends on cdt_pkg and the channel interfaces in cdt_if.sv.
//
// Usage:
//   sample_in carries one 72-bit uniform value as three 24-bit limbs and a
//   sign bit; a transfer happens when valid and ready are both high.
//   sample_out returns the bimodal sample b + (2b-1)*z (6-bit signed) and
//   z*z, where z counts table rows whose threshold exceeds the value.
//   The result reaches sample_out through four register stages (limb
//   compares, row combine, row count, sample/square into the output
//   register).
//   Throughput: one item per cycle while sample_out.ready stays high; every
//   stage has its own valid bit and its own ready, so bubbles close up.
//   Receiver stall: the output register holds its result; stages behind it
//   keep filling until each holds an item, then sample_in.ready drops.
//   Nothing is lost or repeated.
//   Reset (rst, synchronous): clears all stage valid bits; the pipeline
//   comes up empty and ready in the next cycle.
`timescale 1ns / 1ps
`default_nettype none

module cdt_base_gaussian_sampler_unit (
  input  wire         clk,
  input  wire         rst,
  cdt_in_if.sink      sample_in,
  cdt_out_if.source   sample_out
);

  localparam int ROWS    = cdt_pkg::ROWS;
  localparam int LW      = cdt_pkg::LIMB_W;
  localparam int COUNT_W = cdt_pkg::COUNT_W;
  localparam int GROUP   = 6;
  localparam int NGROUPS = (ROWS + GROUP - 1) / GROUP;

  // Stage 1: per-limb compares against every row.
  logic            v1;
  logic            sign1;
  logic [ROWS-1:0] hi_lt1, hi_eq1, mid_lt1, mid_eq1, lo_lt1;
  logic [ROWS-1:0] hi_lt_next, hi_eq_next, mid_lt_next, mid_eq_next, lo_lt_next;

  // Stage 2: value below row threshold.
  logic            v2;
  logic            sign2;
  logic [ROWS-1:0] below2;
  logic [ROWS-1:0] below_next;

  // Stage 3: row count.
  logic               v3;
  logic               sign3;
  logic [COUNT_W-1:0] z3;
  logic [COUNT_W-1:0] z_next;

  // Stage 4: output register.
  logic                                ov;
  logic signed [cdt_pkg::SAMPLE_W-1:0] sample4;
  logic [cdt_pkg::SQUARE_W-1:0]        square4;
  logic [cdt_pkg::SAMPLE_W-1:0]        sample_next;
  logic [cdt_pkg::SQUARE_W-1:0]        square_next;

  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !ov || sample_out.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign sample_in.ready         = rdy1;
  assign sample_out.valid        = ov;
  assign sample_out.bimodal_sample = sample4;
  assign sample_out.count_squared  = square4;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      hi_lt_next[r]  = sample_in.high_limb < cdt_pkg::CDT_THRESHOLD[r][3*LW-1:2*LW];
      hi_eq_next[r]  = sample_in.high_limb == cdt_pkg::CDT_THRESHOLD[r][3*LW-1:2*LW];
      mid_lt_next[r] = sample_in.mid_limb < cdt_pkg::CDT_THRESHOLD[r][2*LW-1:LW];
      mid_eq_next[r] = sample_in.mid_limb == cdt_pkg::CDT_THRESHOLD[r][2*LW-1:LW];
      lo_lt_next[r]  = sample_in.low_limb < cdt_pkg::CDT_THRESHOLD[r][LW-1:0];
    end
  end

  // Borrow chain across the limbs, strictly below only.
  assign below_next = hi_lt1 | (hi_eq1 & (mid_lt1 | (mid_eq1 & lo_lt1)));

  // Count in groups of six bits, then add the group counts.
  always_comb begin
    logic [COUNT_W-1:0] part;
    z_next = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      part = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < ROWS) begin
          part = part + COUNT_W'(below2[g * GROUP + k]);
        end
      end
      z_next = z_next + part;
    end
  end

  always_comb begin
    logic [cdt_pkg::SAMPLE_W-1:0] zx;
    zx = cdt_pkg::SAMPLE_W'(z3);
    if (sign3) begin
      sample_next = zx + cdt_pkg::SAMPLE_W'(1);
    end else begin
      sample_next = '0 - zx;
    end
    square_next = cdt_pkg::SQUARE_W'(z3) * cdt_pkg::SQUARE_W'(z3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (rdy1) v1 <= sample_in.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) ov <= v3;
    end
  end

  // Payload advances with its valid bit; no reset needed.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      sign1   <= sample_in.sign_bit;
      hi_lt1  <= hi_lt_next;
      hi_eq1  <= hi_eq_next;
      mid_lt1 <= mid_lt_next;
      mid_eq1 <= mid_eq_next;
      lo_lt1  <= lo_lt_next;
    end
    if (rdy2) begin
      sign2  <= sign1;
      below2 <= below_next;
    end
    if (rdy3) begin
      sign3 <= sign2;
      z3    <= z_next;
    end
    if (rdy4) begin
      sample4 <= sample_next;
      square4 <= square_next;
    end
  end

  // Thresholds decrease, so the below bits form a thermometer code.
  a_thermometer: assert property (@(posedge clk) disable iff (rst)
    v2 |-> ((below2 >> 1) & ~below2) == '0)
    else $error("row compare bits not a thermometer code");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> z3 <= COUNT_W'(ROWS))
    else $error("row count exceeds table size");

  a_load_output: assert property (@(posedge clk) disable iff (rst)
    (v3 && rdy4) |=> ov)
    else $error("counted item did not reach the output register");

  a_square_match: assert property (@(posedge clk) disable iff (rst)
    (v3 && rdy4) |=> square4 == $past(square_next))
    else $error("output square not loaded from count stage");

endmodule

`default_nettype wire
